>>> sv/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every rising edge, reset included
`define ASSERT_CLK_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/adcu_pkg.sv
// Package for the ADC sample to engineering units block: widths, codes, NTC table
`default_nettype none

package adcu_pkg;

  localparam int REF_MV_W   = 13;
  localparam int FS_W       = 12;
  localparam int SAMPLE_W   = 12;
  localparam int CH_W       = 2;
  localparam int MV_W       = 15;
  localparam int VAL_W      = 19;
  localparam int CFG_IDX_W  = 1;

  localparam logic [MV_W-1:0]  MV_MAX  = 15'd32767;
  localparam logic [VAL_W-1:0] VAL_MAX = 19'd262143;

  localparam logic [REF_MV_W-1:0] REF_MV_RESET = 13'd3300;
  localparam logic [FS_W-1:0]     FS_RESET     = 12'hFFF;

  localparam logic [3:0]        LVD_GAIN    = 4'd11;
  localparam logic [13:0]       R_SCALE     = 14'd10000;
  localparam logic [VAL_W-1:0]  TEMP_OFFSET = 19'd40;

  // shared divider
  localparam int DIV_N_W   = 27;
  localparam int DIV_D_W   = 13;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // thermistor table and search
  localparam int ROM_SIZE      = 161;
  localparam int ROM_IDX_W     = 8;
  localparam int OHMS_W        = 18;
  localparam int TABLE_ENTRIES = 161;
  localparam int TABLE_LIMIT   = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int STEP_W        = (CNT_W > 1) ? $clog2(CNT_W) : 1;
  localparam int SRCH_W        = 9;

  localparam logic [OHMS_W-1:0] NTC_OHMS [ROM_SIZE] = '{
    188500,178600,169200,160400,152100,144300,136900,130000,123400,117200,
    111300,105800,100600,95640,90970,86560,82380,78430,74690,71140,
    67790,64610,61600,58740,56030,53460,51030,48710,46520,44430,
    42450,40570,38780,37080,35460,33930,32460,31070,29750,28490,
    27280,26140,25050,24010,23020,22070,21170,20310,19490,18710,17960,
    17250,16570,15910,15290,14700,14130,13590,13070,12570,12090,
    11640,11200,10780,10380,10000,9633,9282,8945,8622,8312,
    8015,7730,7456,7194,6942,6700,6468,6245,6031,5826,
    5628,5438,5255,5080,4911,4749,4592,4442,4297,4158,
    4024,3895,3771,3651,3536,3425,3318,3215,3115,3019,
    2927,2837,2751,2668,2588,2511,2436,2364,2295,2227,
    2163,2100,2039,1981,1924,1869,1817,1765,1716,1668,
    1622,1577,1534,1492,1451,1412,1374,1337,1302,1267,
    1234,1201,1170,1139,1110,1081,1054,1027,1001,975,
    951,927,904,881,860,838,818,798,779,760,
    742,724,707,690,674,658,643,628,613,599
  };

  localparam logic [CH_W-1:0] CH_LVD  = 2'd0;
  localparam logic [CH_W-1:0] CH_BATT = 2'd1;
  localparam logic [CH_W-1:0] CH_NTC  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_REF_MV     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_MV,
    ST_CHAN,
    ST_DIV_R,
    ST_SRCH,
    ST_TEMP,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

>>> sv/adc_sample_to_engineering_units.sv
// Flow: multiply, millivolt division, channel step, then for a thermistor reading below
// the reference a resistance division, table search and temperature step; the millivolt
// division is skipped when full scale is zero. One item in flight; the next beat is
// taken the cycle after the result is loaded. Uses the shared divider once or twice
// and an 8-probe table search.
// Synchronous active-high reset; config registers return to 3300 mV / 4095 full scale.
`default_nettype none

module adc_sample_to_engineering_units import adcu_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CH_W-1:0]      channel,
  input  wire logic [SAMPLE_W-1:0]  raw_sample,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [MV_W-1:0]           millivolts,
  output logic signed [VAL_W-1:0]   value,
  output logic                      fault,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REF_MV_W-1:0]  cfg_data
);

  state_t state, state_next;

  logic [REF_MV_W-1:0] ref_mv;
  logic [FS_W-1:0]     full_scale;
  logic [CH_W-1:0]     ch_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [MV_W-1:0]     mv;
  logic [VAL_W-1:0]    val_r;
  logic                fault_r;
  logic [DIV_N_W-1:0]  ohms;
  logic [CNT_W-1:0]    cnt;
  logic [STEP_W-1:0]   step;

  logic                div_start;
  logic [DIV_N_W-1:0]  div_dividend;
  logic [DIV_D_W-1:0]  div_divisor;
  logic                div_done;
  logic [DIV_N_W-1:0]  div_q;

  logic [24:0]         mv_prod;
  logic [DIV_N_W-1:0]  r_prod;
  logic [19:0]         lvd_prod;
  logic [17:0]         batt_prod;
  logic                mv_at_ref;
  logic                out_free;
  logic                in_beat;

  logic [CNT_W-1:0]     probe;
  logic [SRCH_W-1:0]    probe_ext;
  logic [ROM_IDX_W-1:0] rom_idx;
  logic                 probe_hit;

  assign cfg_ready = 1'b1;
  assign in_stall  = rst || (state != ST_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign mv_prod   = 25'(ref_mv) * 25'(sample_r);
  assign r_prod    = DIV_N_W'(mv[REF_MV_W-1:0]) * DIV_N_W'(R_SCALE);
  assign lvd_prod  = 20'(mv) * 20'(LVD_GAIN);
  assign batt_prod = 18'(mv) * 18'd5;
  assign mv_at_ref = (mv >= MV_W'(ref_mv));

  assign probe     = cnt | (CNT_W'(1) << step);
  assign probe_ext = SRCH_W'(probe) - SRCH_W'(1);
  assign rom_idx   = probe_ext[ROM_IDX_W-1:0];
  assign probe_hit = (SRCH_W'(probe) <= SRCH_W'(TABLE_LIMIT))
                     && (ohms <= DIV_N_W'(NTC_OHMS[rom_idx]));

  adcu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = DIV_N_W'(mv_prod);
    div_divisor  = DIV_D_W'(full_scale);
    case (state)
      ST_IDLE: begin
        if (in_beat) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (full_scale == '0) begin
          state_next = ST_CHAN;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV_MV;
        end
      end
      ST_DIV_MV: begin
        if (div_done) state_next = ST_CHAN;
      end
      ST_CHAN: begin
        if (ch_r == CH_NTC && !mv_at_ref) begin
          div_start    = 1'b1;
          div_dividend = r_prod;
          div_divisor  = ref_mv - mv[REF_MV_W-1:0];
          state_next   = ST_DIV_R;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIV_R: begin
        if (div_done) state_next = ST_SRCH;
      end
      ST_SRCH: begin
        if (step == '0) state_next = ST_TEMP;
      end
      ST_TEMP: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_mv     <= REF_MV_RESET;
      full_scale <= FS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REF_MV:     ref_mv     <= cfg_data;
        REG_FULL_SCALE: full_scale <= cfg_data[FS_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          ch_r     <= channel;
          sample_r <= raw_sample;
        end
        mv      <= '0;
        fault_r <= 1'b0;
        val_r   <= '0;
      end
      ST_DIV_MV: begin
        if (div_done) begin
          mv <= (|div_q[DIV_N_W-1:MV_W]) ? MV_MAX : div_q[MV_W-1:0];
        end
      end
      ST_CHAN: begin
        case (ch_r)
          CH_LVD:  val_r <= (lvd_prod > 20'(VAL_MAX)) ? VAL_MAX : lvd_prod[VAL_W-1:0];
          CH_BATT: val_r <= VAL_W'(batt_prod[17:1]);
          CH_NTC: begin
            if (mv_at_ref) begin
              fault_r <= 1'b1;
              val_r   <= '0 - TEMP_OFFSET;
            end
          end
          default: val_r <= '0;
        endcase
      end
      ST_DIV_R: begin
        if (div_done) begin
          ohms <= div_q;
          cnt  <= '0;
          step <= STEP_W'(CNT_W - 1);
        end
      end
      ST_SRCH: begin
        if (probe_hit) cnt <= probe;
        if (step != '0) step <= step - 1'b1;
      end
      ST_TEMP: val_r <= VAL_W'(cnt) - TEMP_OFFSET;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      millivolts <= mv;
      value      <= val_r;
      fault      <= fault_r;
    end
  end

endmodule

`default_nettype wire

>>> sv/adcu_div.sv
// Restoring divider, one quotient bit per cycle
`default_nettype none

module adcu_div import adcu_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DIV_N_W-1:0] dividend,
  input  wire logic [DIV_D_W-1:0] divisor,
  output logic                    done,
  output logic [DIV_N_W-1:0]      quotient
);

  logic [DIV_N_W-1:0]   quo;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_D_W:0]     shifted;
  logic                 fits;

  assign shifted = {rem, quo[DIV_N_W-1]};
  assign fits    = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_N_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_N_W-2:0], fits};
      rem <= fits ? DIV_D_W'(shifted - {1'b0, dsr}) : shifted[DIV_D_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

>>> sv/adcu_checker.sv
// Port-level checker for the ADC sample to engineering units block, with its bind
`default_nettype none
`include "assert_macros.svh"

module adcu_props import adcu_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [MV_W-1:0]         millivolts,
  input wire logic signed [VAL_W-1:0] value,
  input wire logic                    fault
);

  logic                  in_beat;
  logic                  out_held;
  logic [MV_W+VAL_W:0]   out_word;

  assign in_beat  = in_valid && !in_stall;
  assign out_held = out_valid && out_stall;
  assign out_word = {millivolts, value, fault};

  `ASSERT_CLK_ALL(a_reset_clears_out, rst |=> !out_valid, "result valid after reset")

  `ASSERT_CLK(a_busy_after_beat, in_beat |=> in_stall, "second beat taken while busy")

  `ASSERT_CLK(a_fault_value, out_valid && fault |-> value == -19'sd40, "fault with wrong value")

  `ASSERT_CLK(a_value_floor, out_valid |-> value >= -19'sd40, "value below -40")

  `ASSERT_CLK(a_out_hold, out_held |=> out_valid && $stable(out_word), "stalled result changed")

endmodule

bind adc_sample_to_engineering_units adcu_props u_adcu_props (.*);

`default_nettype wire
